// ----- rtl/tas_pkg.sv -----
// Package: shared types and constants of the timed action sequencer.
`default_nettype none
package tas_pkg;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_ADD    = 3'd1;
  localparam logic [2:0] CMD_CLEAR  = 3'd2;
  localparam logic [2:0] CMD_START  = 3'd3;
  localparam logic [2:0] CMD_CANCEL = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BUSY    = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_INVALID = 3'd3;
  localparam logic [2:0] ST_UNSUP   = 3'd4;
  localparam logic [2:0] ST_FAULT   = 3'd5;

  localparam logic [2:0] MC_NONE   = 3'd0;
  localparam logic [2:0] MC_STOP   = 3'd1;
  localparam logic [2:0] MC_HOLD   = 3'd2;
  localparam logic [2:0] MC_TURN   = 3'd3;
  localparam logic [2:0] MC_FOLLOW = 3'd4;
  localparam logic [2:0] MC_DRIVE  = 3'd5;

  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_DRIVE    = 4'd1;
  localparam logic [3:0] OP_TURN     = 4'd2;
  localparam logic [3:0] OP_FOLLOW   = 4'd3;
  localparam logic [3:0] OP_DRIVE_MM = 4'd4;
  localparam logic [3:0] OP_WAIT     = 4'd5;
  localparam logic [3:0] OP_STOP     = 4'd6;
  localparam logic [3:0] OP_BRANCH   = 4'd7;
  localparam logic [3:0] OP_END      = 4'd8;
  localparam logic [3:0] OP_LED_ON   = 4'd9;
  localparam logic [3:0] OP_LED_OFF  = 4'd10;
  localparam logic [3:0] OP_LED_TGL  = 4'd11;
  localparam logic [3:0] OP_BUZ_ON   = 4'd12;
  localparam logic [3:0] OP_BUZ_OFF  = 4'd13;
  localparam logic [3:0] OP_BUZ_TGL  = 4'd14;
  localparam logic [3:0] OP_RSVD     = 4'd15;

  localparam logic [2:0] UC_TIMEOUT  = 3'd0;
  localparam logic [2:0] UC_HEADING  = 3'd1;
  localparam logic [2:0] UC_LINE     = 3'd2;
  localparam logic [2:0] UC_LOST     = 3'd3;
  localparam logic [2:0] UC_BUTTON   = 3'd4;
  localparam logic [2:0] UC_DISTANCE = 3'd5;
  localparam logic [2:0] UC_NOW      = 3'd6;
  localparam logic [2:0] UC_NEVER    = 3'd7;

  localparam logic [1:0] CFG_CHASSIS = 2'd0;
  localparam logic [1:0] CFG_LIMIT   = 2'd1;
  localparam logic [1:0] CFG_LED     = 2'd2;
  localparam logic [1:0] CFG_BUZZER  = 2'd3;

  localparam logic [31:0] SEQ_LIMIT_RESET = 32'd60000;
  localparam logic signed [31:0] MM_LIMIT       = 32'sd10000;
  localparam logic signed [31:0] MM_SPEED_LIMIT = 32'sd1000;
  localparam logic signed [31:0] OUT_LEN_MAX    = 32'sd30000;
  localparam logic signed [31:0] OUT_LEN_MIN    = 32'sd50;
  localparam logic [7:0] TARGET_NONE = 8'd255;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [31:0]        now_ms;
    logic [3:0]         op;
    logic signed [31:0] param_a;
    logic signed [31:0] param_b;
    logic [2:0]         until_cond;
    logic [7:0]         success_target;
    logic [7:0]         timeout_target;
    logic               fault;
    logic [2:0]         sensor_flags;
    logic               motion_accepted;
    logic [2:0]         output_ready;
  } item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               running;
    logic               seq_ok;
    logic [7:0]         current_index;
    logic [2:0]         motion_cmd;
    logic signed [31:0] motion_arg_a;
    logic signed [31:0] motion_arg_b;
    logic               led2_on;
    logic               led3_on;
    logic               buzzer_on;
  } result_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_t;

  typedef struct packed {
    logic [7:0] timeout_target;
    logic [7:0] success_target;
    logic [2:0] until_cond;
    logic [3:0] op;
  } ctl_t;

endpackage
`default_nettype wire

// ----- rtl/tas_if.sv -----
// Interfaces: valid/ready channels for items, results and configuration.
`default_nettype none
interface tas_item_if;
  logic            valid;
  logic            ready;
  tas_pkg::item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tas_result_if;
  logic             valid;
  logic             ready;
  tas_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tas_cfg_if;
  logic          valid;
  logic          ready;
  tas_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/timed_action_sequencer_core.sv -----
// Top level: timed action sequencer with program memory.
//
// Channels: in_if carries one command item (tick, add, clear, start,
// cancel); out_if returns one result per item; cfg_if writes the four
// configuration registers (index 0 chassis enable, 1 sequence limit,
// 2 LED enable, 3 buzzer enable); the user must write them only while
// idle, which the block does not enforce. The program lives in a synchronous
// memory with a registered read. An accepted item is registered as the
// entry at the current slot is read, processed in the next cycle and its
// result loaded into the output register; no new item is taken meanwhile.
// An item is accepted once none is being processed and the output
// register is empty or being taken in the same cycle, so a stalled receiver
// stalls input after one pending result. Reset empties the program, stops
// the sequence, turns outputs off and restores register defaults. Memory
// contents are not cleared; only entries below the program count are used.
`default_nettype none
module timed_action_sequencer_core #(
  parameter int PROGRAM_DEPTH = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tas_item_if.sink     in_if,
  tas_result_if.source out_if,
  tas_cfg_if.sink      cfg_if
);
  localparam int AW = $clog2(PROGRAM_DEPTH);
  localparam int CW = $clog2(PROGRAM_DEPTH + 1);

  logic [63:0]        params_mem [PROGRAM_DEPTH];
  tas_pkg::ctl_t      ctl_mem [PROGRAM_DEPTH];
  logic [63:0]        params_rd_q;
  tas_pkg::ctl_t      ctl_rd_q;

  logic        chassis_en_q, led_en_q, buz_en_q;
  logic [31:0] limit_q;
  logic [CW-1:0] count_q, count_d;
  logic [7:0]  slot_q, slot_d;
  logic        run_q, run_d, succ_q, succ_d, started_q, started_d;
  logic [31:0] seq_start_q, seq_start_d, step_start_q, step_start_d;
  logic [2:0]  tact_q, tact_d, lvl_q, lvl_d;
  logic [31:0] tstart_q [3];
  logic [31:0] tstart_d [3];
  logic [14:0] tlen_q [3];
  logic [14:0] tlen_d [3];

  logic           busy_q;
  tas_pkg::item_t item_q;
  tas_pkg::result_t res_q, res_d;
  logic           ovalid_q;
  logic           bad;
  logic           wr_en;

  assign in_if.ready  = !busy_q && (!ovalid_q || out_if.ready);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = ovalid_q;
  assign out_if.data  = res_q;

  tas_check u_check (.item_i(item_q), .bad_o(bad));

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      params_rd_q <= params_mem[slot_q[AW-1:0]];
      ctl_rd_q    <= ctl_mem[slot_q[AW-1:0]];
    end
    if (wr_en) begin
      params_mem[count_q[AW-1:0]] <= {item_q.param_b, item_q.param_a};
      ctl_mem[count_q[AW-1:0]]    <= {item_q.timeout_target, item_q.success_target,
                                      item_q.until_cond, item_q.op};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chassis_en_q <= 1'b1;
      led_en_q     <= 1'b1;
      buz_en_q     <= 1'b1;
      limit_q      <= tas_pkg::SEQ_LIMIT_RESET;
    end else if (cfg_if.valid) begin
      case (cfg_if.data.index)
        tas_pkg::CFG_CHASSIS: chassis_en_q <= cfg_if.data.data[0];
        tas_pkg::CFG_LIMIT:   limit_q      <= cfg_if.data.data;
        tas_pkg::CFG_LED:     led_en_q     <= cfg_if.data.data[0];
        tas_pkg::CFG_BUZZER:  buz_en_q     <= cfg_if.data.data[0];
        default: ;
      endcase
    end
  end

  function automatic logic cond(input logic [2:0] u);
    case (u)
      tas_pkg::UC_HEADING, tas_pkg::UC_DISTANCE: cond = item_q.sensor_flags[0];
      tas_pkg::UC_LINE:   cond = item_q.sensor_flags[1];
      tas_pkg::UC_LOST:   cond = !item_q.sensor_flags[1];
      tas_pkg::UC_BUTTON: cond = item_q.sensor_flags[2];
      tas_pkg::UC_NOW:    cond = 1'b1;
      default:            cond = 1'b0;
    endcase
  endfunction

  always_comb begin
    logic [2:0]  rdy, mask;
    logic        ok, fail, jump_en, jump_ok, done_seq;
    logic [1:0]  verdict;
    logic [7:0]  tgt, nxt;
    logic [31:0] pa, pb, elapsed;
    logic [2:0]  mcmd;
    logic [31:0] ma, mb;
    tas_pkg::ctl_t c;

    count_d = count_q; slot_d = slot_q; run_d = run_q; succ_d = succ_q;
    started_d = started_q; seq_start_d = seq_start_q; step_start_d = step_start_q;
    tact_d = tact_q; lvl_d = lvl_q; tstart_d = tstart_q; tlen_d = tlen_q;
    wr_en = 1'b0;
    rdy = item_q.output_ready;
    mcmd = tas_pkg::MC_NONE; ma = '0; mb = '0;
    res_d = '0;
    res_d.status = tas_pkg::ST_OK;
    ok = 1'b0; fail = 1'b0; jump_en = 1'b0; jump_ok = 1'b0; done_seq = 1'b0;
    verdict = 2'd0; tgt = '0; nxt = '0; mask = '0; elapsed = '0;
    c = ctl_rd_q; pa = params_rd_q[31:0]; pb = params_rd_q[63:32];

    case (item_q.cmd)
      tas_pkg::CMD_TICK: begin
        for (int k = 0; k < 3; k++) begin
          if (tact_q[k] && ((item_q.now_ms - tstart_q[k]) >= {17'd0, tlen_q[k]})) begin
            lvl_d[k] = 1'b0; tact_d[k] = 1'b0; tstart_d[k] = '0; tlen_d[k] = '0;
          end
        end
        if (run_q) begin
          if (item_q.fault ||
              ((item_q.now_ms - seq_start_q) > limit_q)) begin
            done_seq = 1'b1;
          end else if ({8'd0, slot_q} >= {{(16 - CW){1'b0}}, count_q} ||
                       c.op == tas_pkg::OP_END) begin
            done_seq = 1'b1; ok = 1'b1;
          end else begin
            fail = 1'b0;
            if (!started_q) begin
              case (c.op)
                tas_pkg::OP_DRIVE: begin
                  mcmd = tas_pkg::MC_HOLD; ma = pa; fail = !item_q.motion_accepted;
                end
                tas_pkg::OP_TURN: begin
                  mcmd = tas_pkg::MC_TURN; ma = pa; fail = !item_q.motion_accepted;
                end
                tas_pkg::OP_FOLLOW: begin
                  mcmd = tas_pkg::MC_FOLLOW; ma = pa; mb = pb;
                  fail = !item_q.motion_accepted;
                end
                tas_pkg::OP_DRIVE_MM: begin
                  mcmd = tas_pkg::MC_DRIVE; ma = pa; mb = pb;
                  fail = !item_q.motion_accepted;
                end
                tas_pkg::OP_WAIT, tas_pkg::OP_BRANCH: ;
                tas_pkg::OP_STOP: mcmd = tas_pkg::MC_STOP;
                tas_pkg::OP_LED_ON, tas_pkg::OP_LED_OFF, tas_pkg::OP_LED_TGL,
                tas_pkg::OP_BUZ_ON, tas_pkg::OP_BUZ_OFF, tas_pkg::OP_BUZ_TGL: begin
                  if (c.op >= tas_pkg::OP_BUZ_ON) begin
                    mask = 3'b100; fail = !buz_en_q;
                  end else begin
                    mask = (pa == 32'd2) ? 3'b001 : (pa == 32'd3) ? 3'b010 : 3'b011;
                    fail = !led_en_q;
                  end
                  if ((rdy & mask) != mask) fail = 1'b1;
                  if (!fail) begin
                    for (int k = 0; k < 3; k++) begin
                      if (mask[k]) begin
                        if (c.op == tas_pkg::OP_LED_ON || c.op == tas_pkg::OP_BUZ_ON)
                          lvl_d[k] = 1'b1;
                        else if (c.op == tas_pkg::OP_LED_OFF || c.op == tas_pkg::OP_BUZ_OFF)
                          lvl_d[k] = 1'b0;
                        else
                          lvl_d[k] = !lvl_d[k];
                        if (lvl_d[k] && !pb[31] && (pb != 32'd0)) begin
                          tact_d[k] = 1'b1; tstart_d[k] = item_q.now_ms;
                          tlen_d[k] = pb[14:0];
                        end else begin
                          tact_d[k] = 1'b0; tstart_d[k] = '0; tlen_d[k] = '0;
                        end
                      end
                    end
                  end
                end
                default: fail = 1'b1;
              endcase
              if (fail) begin
                mcmd = tas_pkg::MC_STOP; ma = '0; mb = '0;
                for (int k = 0; k < 3; k++) begin
                  if ((k < 2 ? led_en_q : buz_en_q) && rdy[k]) lvl_d[k] = 1'b0;
                  tact_d[k] = 1'b0; tstart_d[k] = '0; tlen_d[k] = '0;
                end
                jump_en = 1'b1; jump_ok = 1'b0; tgt = c.timeout_target;
              end else begin
                started_d = 1'b1; step_start_d = item_q.now_ms;
              end
            end
            if (!fail) begin
              elapsed = item_q.now_ms - step_start_d;
              if (c.op == tas_pkg::OP_STOP) verdict = 2'd1;
              else if (c.op == tas_pkg::OP_BRANCH) verdict = cond(c.until_cond) ? 2'd1 : 2'd2;
              else if (c.op == tas_pkg::OP_DRIVE_MM) verdict = {1'b0, item_q.sensor_flags[0]};
              else if (c.until_cond == tas_pkg::UC_TIMEOUT) verdict = {1'b0, elapsed >= pb};
              else if (elapsed > pb) verdict = 2'd2;
              else verdict = {1'b0, cond(c.until_cond)};
              if (verdict != 2'd0) begin
                mcmd = tas_pkg::MC_STOP; ma = '0; mb = '0;
                succ_d = (verdict == 2'd1);
                jump_en = 1'b1; jump_ok = (verdict == 2'd1);
                tgt = jump_ok ? c.success_target : c.timeout_target;
              end
            end
            if (jump_en) begin
              started_d = 1'b0; step_start_d = '0;
              if (tgt == tas_pkg::TARGET_NONE ||
                  {8'd0, tgt} >= {{(16 - CW){1'b0}}, count_q}) begin
                if (!jump_ok) done_seq = 1'b1;
                else begin
                  nxt = slot_q + 8'd1;
                  slot_d = nxt;
                  if ({8'd0, nxt} >= {{(16 - CW){1'b0}}, count_q}) begin
                    done_seq = 1'b1; ok = 1'b1;
                  end
                end
              end else begin
                slot_d = tgt;
              end
            end
          end
        end
      end
      tas_pkg::CMD_ADD: begin
        if (run_q) res_d.status = tas_pkg::ST_BUSY;
        else if ({{(32 - CW){1'b0}}, count_q} >= PROGRAM_DEPTH) res_d.status = tas_pkg::ST_FULL;
        else if (bad) res_d.status = tas_pkg::ST_INVALID;
        else begin
          wr_en = busy_q; count_d = count_q + 1'b1;
        end
      end
      tas_pkg::CMD_CLEAR: begin
        if (run_q) res_d.status = tas_pkg::ST_BUSY;
        else begin
          count_d = '0; slot_d = '0; succ_d = 1'b0;
          for (int k = 0; k < 3; k++) begin
            if ((k < 2 ? led_en_q : buz_en_q) && rdy[k]) lvl_d[k] = 1'b0;
            tact_d[k] = 1'b0; tstart_d[k] = '0; tlen_d[k] = '0;
          end
        end
      end
      tas_pkg::CMD_START: begin
        if (!chassis_en_q) begin
          mcmd = tas_pkg::MC_STOP; res_d.status = tas_pkg::ST_UNSUP;
        end else if (run_q) res_d.status = tas_pkg::ST_BUSY;
        else begin
          for (int k = 0; k < 3; k++) begin
            if ((k < 2 ? led_en_q : buz_en_q) && rdy[k]) lvl_d[k] = 1'b0;
            tact_d[k] = 1'b0; tstart_d[k] = '0; tlen_d[k] = '0;
          end
          if (count_q == '0) res_d.status = tas_pkg::ST_INVALID;
          else if (item_q.fault) res_d.status = tas_pkg::ST_FAULT;
          else begin
            slot_d = '0; run_d = 1'b1; succ_d = 1'b0;
            seq_start_d = item_q.now_ms; started_d = 1'b0; step_start_d = '0;
          end
        end
      end
      tas_pkg::CMD_CANCEL: done_seq = 1'b1;
      default: res_d.status = tas_pkg::ST_UNSUP;
    endcase

    if (done_seq) begin
      run_d = 1'b0; succ_d = ok; mcmd = tas_pkg::MC_STOP; ma = '0; mb = '0;
      for (int k = 0; k < 3; k++) begin
        if ((k < 2 ? led_en_q : buz_en_q) && rdy[k]) lvl_d[k] = 1'b0;
        tact_d[k] = 1'b0; tstart_d[k] = '0; tlen_d[k] = '0;
      end
    end

    res_d.running       = run_d;
    res_d.seq_ok        = succ_d;
    res_d.current_index = slot_d;
    res_d.motion_cmd    = mcmd;
    res_d.motion_arg_a  = ma;
    res_d.motion_arg_b  = mb;
    res_d.led2_on       = lvl_d[0];
    res_d.led3_on       = lvl_d[1];
    res_d.buzzer_on     = lvl_d[2];
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) item_q <= in_if.data;
    if (busy_q) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; ovalid_q <= 1'b0;
      count_q <= '0; slot_q <= '0; run_q <= 1'b0; succ_q <= 1'b0; started_q <= 1'b0;
      seq_start_q <= '0; step_start_q <= '0; tact_q <= '0; lvl_q <= '0;
      for (int k = 0; k < 3; k++) begin
        tstart_q[k] <= '0; tlen_q[k] <= '0;
      end
    end else begin
      busy_q <= in_if.valid && in_if.ready;
      if (busy_q) ovalid_q <= 1'b1;
      else if (out_if.ready) ovalid_q <= 1'b0;
      if (busy_q) begin
        count_q <= count_d; slot_q <= slot_d; run_q <= run_d; succ_q <= succ_d;
        started_q <= started_d; seq_start_q <= seq_start_d;
        step_start_q <= step_start_d; tact_q <= tact_d; lvl_q <= lvl_d;
        tstart_q <= tstart_d; tlen_q <= tlen_d;
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/tas_check.sv -----
// Add-instruction argument check.
`default_nettype none
module tas_check (
  input  tas_pkg::item_t item_i,
  output logic           bad_o
);
  logic led, buz, off, bad_len, bad_op;
  logic signed [31:0] a, b;

  always_comb begin
    a = item_i.param_a;
    b = item_i.param_b;
    led = item_i.op inside {[tas_pkg::OP_LED_ON:tas_pkg::OP_LED_TGL]};
    buz = item_i.op inside {[tas_pkg::OP_BUZ_ON:tas_pkg::OP_BUZ_TGL]};
    off = (item_i.op == tas_pkg::OP_LED_OFF) || (item_i.op == tas_pkg::OP_BUZ_OFF);
    bad_len = (b < 0) || (b > tas_pkg::OUT_LEN_MAX) ||
              ((b > 0) && (b < tas_pkg::OUT_LEN_MIN)) || (off && (b != 0));
    bad_op = (item_i.op == tas_pkg::OP_NONE) || (item_i.op == tas_pkg::OP_RSVD);
    bad_o = bad_op ||
      ((item_i.op == tas_pkg::OP_DRIVE_MM) && ((a == 0) || (a < -tas_pkg::MM_LIMIT) ||
        (a > tas_pkg::MM_LIMIT) || (b <= 0) || (b > tas_pkg::MM_SPEED_LIMIT) ||
        (item_i.until_cond != tas_pkg::UC_DISTANCE))) ||
      (led && (((a != 0) && (a != 2) && (a != 3)) || bad_len ||
        (item_i.until_cond != tas_pkg::UC_NOW))) ||
      (buz && ((a != 0) || bad_len || (item_i.until_cond != tas_pkg::UC_NOW)));
  end
endmodule
`default_nettype wire

// ----- verif/tas_checker.sv -----
// Checker: watches the sequencer channels, predicts each result and compares.
`timescale 1ns / 100ps
module tas_checker
  import tas_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  tas_item_if   in_if,
  tas_result_if out_if,
  tas_cfg_if    cfg_if,
  output int    err_count,
  output int    pending
);

  logic [63:0] prog_par [64];
  ctl_t        prog_ctl [64];
  int unsigned prog_cnt;
  logic [7:0]  slot;
  bit          run, ok_flag, begun;
  logic [31:0] seq_t0, step_t0;
  bit   [2:0]  t_act;
  logic [31:0] t_t0 [3];
  logic [14:0] t_len [3];
  logic [2:0]  lvl;
  logic [2:0]  mc;
  logic [31:0] ma, mb;
  bit          chas, led_en, buz_en;
  logic [31:0] lim;
  result_t     want_q [$];

  assign pending = want_q.size();

  function automatic void set_mc(logic [2:0] c, logic [31:0] a, logic [31:0] b);
    mc = c; ma = a; mb = b;
  endfunction

  function automatic void clr_timer(int k);
    t_act[k] = 0; t_t0[k] = '0; t_len[k] = '0;
  endfunction

  function automatic void drop_outputs(logic [2:0] rdy);
    for (int k = 0; k < 3; k++) begin
      if (((k < 2) ? led_en : buz_en) && rdy[k]) lvl[k] = 1'b0;
      clr_timer(k);
    end
  endfunction

  function automatic void finish_seq(bit ok, logic [2:0] rdy);
    run = 0;
    ok_flag = ok;
    set_mc(MC_STOP, '0, '0);
    drop_outputs(rdy);
  endfunction

  function automatic void take_jump(logic [7:0] tgt, bit ok, logic [2:0] rdy);
    begun = 0;
    step_t0 = '0;
    if (tgt == TARGET_NONE || tgt >= prog_cnt) begin
      if (!ok) begin
        finish_seq(0, rdy);
        return;
      end
      slot = slot + 8'd1;
      if (slot >= prog_cnt) finish_seq(1, rdy);
    end else begin
      slot = tgt;
    end
  endfunction

  function automatic bit cond_met(logic [2:0] c, logic [2:0] f);
    case (c)
      UC_HEADING, UC_DISTANCE: return f[0];
      UC_LINE:                 return f[1];
      UC_LOST:                 return !f[1];
      UC_BUTTON:               return f[2];
      UC_NOW:                  return 1'b1;
      default:                 return 1'b0;
    endcase
  endfunction

  function automatic void drive_outputs(logic [3:0] op, logic [2:0] mask,
                                        logic [31:0] pb, logic [31:0] now);
    for (int k = 0; k < 3; k++) begin
      if (mask[k]) begin
        if (op == OP_LED_ON || op == OP_BUZ_ON) lvl[k] = 1'b1;
        else if (op == OP_LED_OFF || op == OP_BUZ_OFF) lvl[k] = 1'b0;
        else lvl[k] = !lvl[k];
        if (lvl[k] && $signed(pb) > 0) begin
          t_act[k] = 1; t_t0[k] = now; t_len[k] = pb[14:0];
        end else begin
          clr_timer(k);
        end
      end
    end
  endfunction

  function automatic bit launch(logic [3:0] op, logic [31:0] pa, logic [31:0] pb,
                                logic [31:0] now, logic acc, logic [2:0] rdy);
    int a;
    logic [2:0] mask;
    a = $signed(pa);
    case (op)
      OP_DRIVE:    begin set_mc(MC_HOLD, pa, '0); return acc; end
      OP_TURN:     begin set_mc(MC_TURN, pa, '0); return acc; end
      OP_FOLLOW:   begin set_mc(MC_FOLLOW, pa, pb); return acc; end
      OP_DRIVE_MM: begin set_mc(MC_DRIVE, pa, pb); return acc; end
      OP_WAIT, OP_BRANCH, OP_END: return 1'b1;
      OP_STOP:     begin set_mc(MC_STOP, '0, '0); return 1'b1; end
      OP_LED_ON, OP_LED_OFF, OP_LED_TGL: begin
        if (!led_en) return 1'b0;
        mask = (a == 2) ? 3'b001 : (a == 3) ? 3'b010 : 3'b011;
        if ((rdy & mask) != mask) return 1'b0;
        drive_outputs(op, mask, pb, now);
        return 1'b1;
      end
      OP_BUZ_ON, OP_BUZ_OFF, OP_BUZ_TGL: begin
        if (!buz_en || !rdy[2]) return 1'b0;
        drive_outputs(op, 3'b100, pb, now);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void do_tick(item_t it);
    logic [31:0] now, pa, pb, el, d;
    logic [2:0]  rdy;
    ctl_t        c;
    int          v;
    now = it.now_ms;
    rdy = it.output_ready;
    for (int k = 0; k < 3; k++) begin
      d = now - t_t0[k];
      if (t_act[k] && d >= {17'd0, t_len[k]}) begin
        lvl[k] = 1'b0;
        clr_timer(k);
      end
    end
    if (!run) return;
    if (it.fault) begin finish_seq(0, rdy); return; end
    d = now - seq_t0;
    if (d > lim) begin finish_seq(0, rdy); return; end
    if (slot >= prog_cnt) begin finish_seq(1, rdy); return; end
    c  = prog_ctl[slot];
    pa = prog_par[slot][31:0];
    pb = prog_par[slot][63:32];
    if (c.op == OP_END) begin finish_seq(1, rdy); return; end
    if (!begun) begin
      if (!launch(c.op, pa, pb, now, it.motion_accepted, rdy)) begin
        set_mc(MC_STOP, '0, '0);
        drop_outputs(rdy);
        take_jump(c.timeout_target, 0, rdy);
        return;
      end
      begun = 1;
      step_t0 = now;
    end
    el = now - step_t0;
    if (c.op == OP_STOP) v = 1;
    else if (c.op == OP_BRANCH) v = cond_met(c.until_cond, it.sensor_flags) ? 1 : 2;
    else if (c.op == OP_DRIVE_MM) v = it.sensor_flags[0] ? 1 : 0;
    else if (c.until_cond == UC_TIMEOUT) v = (el >= pb) ? 1 : 0;
    else if (el > pb) v = 2;
    else v = cond_met(c.until_cond, it.sensor_flags) ? 1 : 0;
    if (v == 0) return;
    set_mc(MC_STOP, '0, '0);
    ok_flag = (v == 1);
    if (v == 1) take_jump(c.success_target, 1, rdy);
    else take_jump(c.timeout_target, 0, rdy);
  endfunction

  function automatic logic [2:0] do_add(item_t it);
    int a, b;
    bit led, buz, off, bad_len;
    a = it.param_a;
    b = it.param_b;
    led = (it.op >= OP_LED_ON && it.op <= OP_LED_TGL);
    buz = (it.op >= OP_BUZ_ON && it.op <= OP_BUZ_TGL);
    off = (it.op == OP_LED_OFF || it.op == OP_BUZ_OFF);
    bad_len = (b < 0) || (b > OUT_LEN_MAX) || (b > 0 && b < OUT_LEN_MIN) || (off && b != 0);
    if (run) return ST_BUSY;
    if (prog_cnt >= 64) return ST_FULL;
    if (it.op == OP_NONE || it.op > OP_BUZ_TGL) return ST_INVALID;
    if (it.op == OP_DRIVE_MM && (a == 0 || a < -MM_LIMIT || a > MM_LIMIT || b <= 0 ||
                                 b > MM_SPEED_LIMIT || it.until_cond != UC_DISTANCE))
      return ST_INVALID;
    if (led && ((a != 0 && a != 2 && a != 3) || bad_len || it.until_cond != UC_NOW))
      return ST_INVALID;
    if (buz && (a != 0 || bad_len || it.until_cond != UC_NOW)) return ST_INVALID;
    prog_par[prog_cnt] = {it.param_b, it.param_a};
    prog_ctl[prog_cnt] = '{it.timeout_target, it.success_target, it.until_cond, it.op};
    prog_cnt++;
    return ST_OK;
  endfunction

  function automatic result_t seq_step(item_t it);
    result_t r;
    logic [2:0] st;
    st = ST_OK;
    set_mc(MC_NONE, '0, '0);
    case (it.cmd)
      CMD_TICK: do_tick(it);
      CMD_ADD:  st = do_add(it);
      CMD_CLEAR: begin
        if (run) st = ST_BUSY;
        else begin
          prog_cnt = 0; slot = '0; ok_flag = 0;
          drop_outputs(it.output_ready);
        end
      end
      CMD_START: begin
        if (!chas) begin set_mc(MC_STOP, '0, '0); st = ST_UNSUP; end
        else if (run) st = ST_BUSY;
        else begin
          drop_outputs(it.output_ready);
          if (prog_cnt == 0) st = ST_INVALID;
          else if (it.fault) st = ST_FAULT;
          else begin
            slot = '0; run = 1; ok_flag = 0; seq_t0 = it.now_ms;
            begun = 0; step_t0 = '0;
          end
        end
      end
      CMD_CANCEL: finish_seq(0, it.output_ready);
      default: st = ST_UNSUP;
    endcase
    r.status = st;
    r.running = run;
    r.seq_ok = ok_flag;
    r.current_index = slot;
    r.motion_cmd = mc;
    r.motion_arg_a = ma;
    r.motion_arg_b = mb;
    r.led2_on = lvl[0];
    r.led3_on = lvl[1];
    r.buzzer_on = lvl[2];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t w, g;
    if (!rst_ni) begin
      chas = 1; lim = SEQ_LIMIT_RESET; led_en = 1; buz_en = 1;
      prog_cnt = 0; slot = '0; run = 0; ok_flag = 0; begun = 0;
      seq_t0 = '0; step_t0 = '0; lvl = '0;
      for (int k = 0; k < 3; k++) clr_timer(k);
      want_q.delete();
      err_count = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        g = out_if.data;
        if (want_q.size() == 0) begin
          $error("result transfer with nothing expected");
          err_count++;
        end else begin
          w = want_q.pop_front();
          if (g.status !== w.status) begin
            $error("status exp %0d got %0d", w.status, g.status); err_count++;
          end
          if (g.running !== w.running) begin
            $error("running exp %0d got %0d", w.running, g.running); err_count++;
          end
          if (g.seq_ok !== w.seq_ok) begin
            $error("seq_ok exp %0d got %0d", w.seq_ok, g.seq_ok);
            err_count++;
          end
          if (g.current_index !== w.current_index) begin
            $error("current_index exp %0d got %0d", w.current_index, g.current_index);
            err_count++;
          end
          if (g.motion_cmd !== w.motion_cmd) begin
            $error("motion_cmd exp %0d got %0d", w.motion_cmd, g.motion_cmd); err_count++;
          end
          if (g.motion_arg_a !== w.motion_arg_a) begin
            $error("motion_arg_a exp %0d got %0d", w.motion_arg_a, g.motion_arg_a);
            err_count++;
          end
          if (g.motion_arg_b !== w.motion_arg_b) begin
            $error("motion_arg_b exp %0d got %0d", w.motion_arg_b, g.motion_arg_b);
            err_count++;
          end
          if (g.led2_on !== w.led2_on) begin
            $error("led2_on exp %0d got %0d", w.led2_on, g.led2_on); err_count++;
          end
          if (g.led3_on !== w.led3_on) begin
            $error("led3_on exp %0d got %0d", w.led3_on, g.led3_on); err_count++;
          end
          if (g.buzzer_on !== w.buzzer_on) begin
            $error("buzzer_on exp %0d got %0d", w.buzzer_on, g.buzzer_on); err_count++;
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.data.index)
          CFG_CHASSIS: chas = cfg_if.data.data[0];
          CFG_LIMIT:   lim = cfg_if.data.data;
          CFG_LED:     led_en = cfg_if.data.data[0];
          CFG_BUZZER:  buz_en = cfg_if.data.data[0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) want_q.push_back(seq_step(in_if.data));
    end
  end

endmodule

// ----- verif/tb.sv -----
// Testbench top: drives programs, ticks and register writes into the sequencer.
`timescale 1ns / 100ps
module tb;
  import tas_pkg::*;

  logic clk, rst_n;
  int   errs, pending;
  int   n_items, n_runs, n_cfg, idle_cyc, hold;
  bit   quiet;
  logic [31:0] clock_ms;

  tas_item_if   in_if ();
  tas_result_if out_if ();
  tas_cfg_if    cfg_if ();

  timed_action_sequencer_core u_top (
    .clk_i (clk), .rst_ni (rst_n), .in_if (in_if), .out_if (out_if), .cfg_if (cfg_if)
  );

  tas_checker u_chk (
    .clk_i (clk), .rst_ni (rst_n), .in_if (in_if), .out_if (out_if), .cfg_if (cfg_if),
    .err_count (errs), .pending (pending)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  always @(negedge clk) begin
    if (quiet) out_if.ready <= 1'b1;
    else if (hold > 0) begin
      out_if.ready <= 1'b0;
      hold--;
    end else if ($urandom_range(0, 7) == 0) begin
      out_if.ready <= 1'b0;
      hold = $urandom_range(0, 10);
    end else out_if.ready <= 1'b1;
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cyc = 0;
    else idle_cyc++;
    if (idle_cyc >= 2000) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic push(item_t it);
    int n;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 11);
      in_if.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    n_items++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{idx, val};
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    n_cfg++;
  endtask

  task automatic set_regs(bit ch, logic [31:0] lim, bit led, bit buz);
    drain();
    cfg_write(CFG_CHASSIS, {31'd0, ch});
    cfg_write(CFG_LIMIT, lim);
    cfg_write(CFG_LED, {31'd0, led});
    cfg_write(CFG_BUZZER, {31'd0, buz});
  endtask

  function automatic item_t noise();
    item_t it;
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    it.cmd = 3'($urandom_range(0, 7));
    return it;
  endfunction

  function automatic item_t mk(logic [2:0] cmd);
    item_t it;
    it = noise();
    it.cmd = cmd;
    it.now_ms = clock_ms;
    it.fault = ($urandom_range(0, 19) == 0);
    it.motion_accepted = ($urandom_range(0, 7) != 0);
    it.output_ready = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'b111;
    return it;
  endfunction

  function automatic logic [7:0] pick_tgt(int cnt);
    return ($urandom_range(0, 1) == 0) ? TARGET_NONE : 8'($urandom_range(0, cnt + 2));
  endfunction

  function automatic item_t mk_instr(int cnt);
    item_t it;
    it = mk(CMD_ADD);
    it.op = 4'($urandom_range(1, 14));
    it.until_cond = 3'($urandom_range(0, 7));
    it.param_b = $urandom_range(0, 40);
    case (it.op)
      OP_DRIVE_MM: begin
        it.param_a = $urandom_range(1, 10000);
        if ($urandom_range(0, 1)) it.param_a = -it.param_a;
        it.param_b = $urandom_range(1, 1000);
        it.until_cond = UC_DISTANCE;
      end
      OP_WAIT: it.until_cond = UC_TIMEOUT;
      OP_LED_ON, OP_LED_OFF, OP_LED_TGL, OP_BUZ_ON, OP_BUZ_OFF, OP_BUZ_TGL: begin
        it.param_a = (it.op >= OP_BUZ_ON) ? 0 : (($urandom_range(0, 2) == 0) ? 0 :
                     $urandom_range(2, 3));
        it.param_b = ($urandom_range(0, 1) || it.op == OP_LED_OFF || it.op == OP_BUZ_OFF)
                     ? 0 : $urandom_range(50, 200);
        it.until_cond = UC_NOW;
      end
      default: ;
    endcase
    it.success_target = pick_tgt(cnt);
    it.timeout_target = pick_tgt(cnt);
    return it;
  endfunction

  task automatic run_program();
    item_t it;
    int n, t;
    if ($urandom_range(0, 3) != 0) push(mk(CMD_CANCEL));
    push(mk(CMD_CLEAR));
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) push(($urandom_range(0, 9) == 0) ? mk(CMD_ADD) : mk_instr(n));
    push(mk(CMD_START));
    n_runs++;
    t = $urandom_range(5, 60);
    for (int i = 0; i < t; i++) begin
      clock_ms += ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 15);
      if ($urandom_range(0, 19) == 0) it = noise();
      else begin
        it = mk(CMD_TICK);
        it.fault = ($urandom_range(0, 39) == 0);
      end
      push(it);
    end
  endtask

  initial begin
    item_t it;
    int blk;
    rst_n = 1'b0;
    in_if.valid = 1'b0; in_if.data = '0;
    cfg_if.valid = 1'b0; cfg_if.data = '0;
    n_items = 0; n_runs = 0; n_cfg = 0; quiet = 0;
    clock_ms = $urandom;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    push(mk(CMD_TICK));
    it = mk(CMD_START); it.fault = 0; push(it);
    it = mk(CMD_ADD); it.op = OP_NONE; push(it);
    it = mk(CMD_ADD); it.op = OP_RSVD; push(it);
    it = mk(CMD_ADD); it.op = OP_DRIVE_MM; it.param_a = 32'sh8000_0000;
    it.param_b = 32'sh7fff_ffff; it.until_cond = UC_DISTANCE; push(it);
    it = mk(CMD_ADD); it.op = OP_LED_ON; it.param_a = 0; it.param_b = 25;
    it.until_cond = UC_NOW; push(it);
    it = mk(CMD_ADD); it.op = OP_WAIT; it.param_b = -1; it.until_cond = UC_NEVER; push(it);
    it = mk(CMD_ADD); it.op = OP_LED_ON; it.param_a = 0; it.param_b = 60;
    it.until_cond = UC_NOW; it.success_target = TARGET_NONE; push(it);
    it = mk(CMD_ADD); it.op = OP_BUZ_TGL; it.param_a = 0; it.param_b = 0;
    it.until_cond = UC_NOW; it.success_target = TARGET_NONE; push(it);
    it = mk(CMD_ADD); it.op = OP_END; it.until_cond = UC_NOW; push(it);
    it = mk(CMD_START); it.fault = 1; push(it);
    it = mk(CMD_START); it.fault = 0; push(it);
    push(mk(CMD_START));
    push(mk(CMD_ADD));
    push(mk(CMD_CLEAR));
    for (int i = 0; i < 4; i++) begin
      it = mk(CMD_TICK); it.fault = 0; it.output_ready = 3'b111; push(it);
      clock_ms += 30;
    end
    for (int c = 5; c < 8; c++) push(mk(3'(c)));
    push(mk(CMD_CANCEL));

    blk = 0;
    while (n_items < 1750) begin
      quiet = (n_items > 1550);
      if (blk % 8 == 0) begin
        case (blk / 8)
          0: set_regs(1, SEQ_LIMIT_RESET, 1, 1);
          1: set_regs(0, 32'd1, 1, 0);
          2: set_regs(1, 32'hffff_ffff, 0, 0);
          3: set_regs(1, 32'd1, 0, 1);
          default: set_regs($urandom_range(0, 4) != 0, ($urandom_range(0, 3) == 0) ?
                            $urandom : $urandom_range(1, 600), $urandom_range(0, 1),
                            $urandom_range(0, 1));
        endcase
      end
      if (blk == 5) begin
        push(mk(CMD_CANCEL));
        push(mk(CMD_CLEAR));
        for (int i = 0; i < 66; i++) push(mk_instr(64));
      end else run_program();
      blk++;
    end

    drain();
    repeat (10) @(posedge clk);
    $display("tb: %0d items over %0d program runs, %0d register writes", n_items, n_runs,
             n_cfg);
    if (errs == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
